### rtl/aldb_pkg.sv
// shared types, constants and register codes of the ladder keypad decoder
package aldb_pkg;

	localparam int ADC_W         = 10;
	localparam int TIME_W        = 32;
	localparam int IDX_W         = 2;
	localparam int BIU_W         = 3;
	localparam int TICKS_W       = 16;
	localparam int SAMPLES_W     = 8;
	localparam int NUM_LEVELS    = 4;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 16;

	localparam int NUM_BUTTONS_DEF   = 4;
	localparam int WINDOW_MARGIN_DEF = 20;
	localparam int QUEUE_DEPTH       = 2;

	localparam logic [TICKS_W-1:0]   DEBOUNCE_RST = TICKS_W'(25);
	localparam logic [TICKS_W-1:0]   INTERVAL_RST = TICKS_W'(15);
	localparam logic [SAMPLES_W-1:0] REQUIRED_RST = SAMPLES_W'(4);
	localparam logic [SAMPLES_W-1:0] SAMPLES_MAX  = '1;

	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IN_USE    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_REQUIRED  = 3'd7;

	typedef struct packed {
		logic [NUM_LEVELS-1:0][ADC_W-1:0] level;
		logic [BIU_W-1:0]                 buttons_in_use;
		logic [TICKS_W-1:0]               debounce_ticks;
		logic [TICKS_W-1:0]               report_interval_ticks;
		logic [SAMPLES_W-1:0]             required_samples;
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  button;
		logic [TIME_W-1:0] event_time;
	} decoded_t;

	localparam int DECODED_W = $bits(decoded_t);

endpackage

### rtl/aldb_ifs.sv
// handshake channel interfaces: samples, results, register writes
interface aldb_sample_if import aldb_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] event_time;
	logic [ADC_W-1:0]  adc_sample;

	modport source (output valid, output event_time, output adc_sample, input ready);
	modport sink (input valid, input event_time, input adc_sample, output ready);
endinterface

interface aldb_result_if import aldb_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             pressed;
	logic [IDX_W-1:0] button_index;

	modport source (output valid, output pressed, output button_index, input ready);
	modport sink (input valid, input pressed, input button_index, output ready);
endinterface

interface aldb_cfg_if import aldb_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

### rtl/aldb_front.sv
// front end: window check and nearest-level match of each sample
module aldb_front import aldb_pkg::*; #(
	parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
	parameter int WINDOW_MARGIN = WINDOW_MARGIN_DEF
) (
	aldb_sample_if.sink in,
	input  cfg_t        cfg,
	input  logic        full,
	output logic        push,
	output decoded_t    push_data
);

	localparam int SW = $clog2((2 ** ADC_W) + WINDOW_MARGIN);

	logic [BIU_W-1:0]                  n_active;
	logic [ADC_W-1:0]                  lo;
	logic [ADC_W-1:0]                  hi;
	logic [NUM_BUTTONS-1:0][ADC_W-1:0] level_dist;
	logic [ADC_W-1:0]                  best_dist;
	logic [IDX_W-1:0]                  best;
	logic                              below;
	logic                              above;

	always_comb begin
		n_active = (cfg.buttons_in_use > BIU_W'(NUM_BUTTONS)) ? BIU_W'(NUM_BUTTONS)
			: cfg.buttons_in_use;
		lo = cfg.level[0];
		hi = cfg.level[0];
		for (int i = 1; i < NUM_BUTTONS; i++) begin
			if (BIU_W'(i) < n_active) begin
				if (cfg.level[i] < lo) lo = cfg.level[i];
				if (cfg.level[i] > hi) hi = cfg.level[i];
			end
		end
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			level_dist[i] = (in.adc_sample >= cfg.level[i]) ? in.adc_sample - cfg.level[i]
				: cfg.level[i] - in.adc_sample;
		end
		best      = '0;
		best_dist = level_dist[0];
		for (int i = 1; i < NUM_BUTTONS; i++) begin
			if (BIU_W'(i) < n_active && level_dist[i] < best_dist) begin
				best_dist = level_dist[i];
				best      = IDX_W'(i);
			end
		end
	end

	assign below = (SW'(in.adc_sample) + SW'(WINDOW_MARGIN)) < SW'(lo);
	assign above = SW'(in.adc_sample) > (SW'(hi) + SW'(WINDOW_MARGIN));

	assign push                 = in.valid && !full;
	assign in.ready             = !full;
	assign push_data.hit        = (n_active != '0) && !below && !above;
	assign push_data.button     = best;
	assign push_data.event_time = in.event_time;

endmodule

### rtl/aldb_queue.sv
// short fifo between decode and debounce
module aldb_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             pop_valid,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [DEPTH-1:0][WIDTH-1:0] mem_q;
	logic [PW-1:0]               wr_ptr_q;
	logic [PW-1:0]               rd_ptr_q;
	logic [CW-1:0]               count_q;
	logic                        do_push;
	logic                        do_pop;

	assign full      = count_q == CW'(DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop) count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

### rtl/aldb_back.sv
// back end: debounce state, report decision and output register
module aldb_back import aldb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          q_valid,
	input  decoded_t      q_data,
	output logic          pop,
	aldb_result_if.source out
);

	logic [IDX_W-1:0]     last_idx_q;
	logic                 last_valid_q;
	logic [TIME_W-1:0]    start_q;
	logic [TIME_W-1:0]    report_q;
	logic [SAMPLES_W-1:0] stable_q;
	logic                 out_valid_q;
	logic                 pressed_q;
	logic [IDX_W-1:0]     button_q;

	logic                 same;
	logic [SAMPLES_W-1:0] stable_next;
	logic [TIME_W-1:0]    start_next;
	logic [TIME_W-1:0]    since_start;
	logic [TIME_W-1:0]    since_report;
	logic                 fire;

	assign pop = q_valid && (!out_valid_q || out.ready);

	always_comb begin
		same         = last_valid_q && (last_idx_q == q_data.button);
		stable_next  = !same ? '0 : (stable_q == SAMPLES_MAX) ? stable_q : stable_q + 1'b1;
		start_next   = same ? start_q : q_data.event_time;
		since_start  = q_data.event_time - start_next;
		since_report = q_data.event_time - report_q;
		fire = q_data.hit && same
			&& since_start >= TIME_W'(cfg.debounce_ticks)
			&& since_report >= TIME_W'(cfg.report_interval_ticks)
			&& stable_next >= cfg.required_samples;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_idx_q   <= '0;
			last_valid_q <= 1'b0;
			start_q      <= '0;
			report_q     <= '0;
			stable_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				if (q_data.hit) begin
					last_idx_q   <= q_data.button;
					last_valid_q <= 1'b1;
					start_q      <= start_next;
					stable_q     <= stable_next;
					if (fire) report_q <= q_data.event_time;
				end
			end else if (out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			pressed_q <= fire;
			button_q  <= fire ? q_data.button : '0;
		end
	end

	assign out.valid        = out_valid_q;
	assign out.pressed      = pressed_q;
	assign out.button_index = button_q;

endmodule

### rtl/adc_ladder_button_debouncer.sv
// top level: register file, decode front, queue and debounce back
//
//  channel | dir | beat holds                      | accepted when
//  in      | in  | event_time, adc_sample          | in.valid && in.ready
//  out     | out | pressed, button_index           | out.valid && out.ready
//  cfg     | in  | index, wdata                    | cfg.valid && cfg.ready
//
// one beat per cycle while out is ready; a result leaves from the output register
// decode is combinational logic in front of a two-entry queue, debounce updates
// state and the output register in the cycle it pops the queue
// out stalls fill the queue, then in.ready drops; cfg is always ready
// asynchronous reset clears the registers to their defaults and the debounce state
module adc_ladder_button_debouncer import aldb_pkg::*; #(
	parameter int NUM_BUTTONS   = NUM_BUTTONS_DEF,
	parameter int WINDOW_MARGIN = WINDOW_MARGIN_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	aldb_sample_if.sink   in,
	aldb_result_if.source out,
	aldb_cfg_if.sink      cfg
);

	cfg_t     cfg_q;
	logic     full;
	logic     push;
	decoded_t push_data;
	logic     pop;
	logic     q_valid;
	decoded_t q_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level                 <= '0;
			cfg_q.buttons_in_use        <= '0;
			cfg_q.debounce_ticks        <= DEBOUNCE_RST;
			cfg_q.report_interval_ticks <= INTERVAL_RST;
			cfg_q.required_samples      <= REQUIRED_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_LEVEL_0, REG_LEVEL_1, REG_LEVEL_2, REG_LEVEL_3: begin
					cfg_q.level[cfg.index[IDX_W-1:0]] <= cfg.wdata[ADC_W-1:0];
				end
				REG_IN_USE:   cfg_q.buttons_in_use        <= cfg.wdata[BIU_W-1:0];
				REG_DEBOUNCE: cfg_q.debounce_ticks        <= cfg.wdata[TICKS_W-1:0];
				REG_INTERVAL: cfg_q.report_interval_ticks <= cfg.wdata[TICKS_W-1:0];
				REG_REQUIRED: cfg_q.required_samples      <= cfg.wdata[SAMPLES_W-1:0];
				default: ;
			endcase
		end
	end

	aldb_front #(
		.NUM_BUTTONS   (NUM_BUTTONS),
		.WINDOW_MARGIN (WINDOW_MARGIN)
	) u_front (
		.in        (in),
		.cfg       (cfg_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	aldb_queue #(
		.WIDTH (DECODED_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	aldb_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_data  (q_data),
		.pop     (pop),
		.out     (out)
	);

endmodule

### rtl/aldb_checker.sv
// port-level checks of the decoder, bound to the top level
module aldb_checker import aldb_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             out_pressed,
	input logic [IDX_W-1:0] out_button_index
);

	localparam int OW = $clog2(QUEUE_DEPTH + 2);

	logic [OW-1:0] inflight_q;
	logic          in_beat;
	logic          out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_beat && !out_beat) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_beat && !in_beat) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pressed)
			&& $stable(out_button_index))
		else $error("result changed while stalled");

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_pressed |-> out_button_index == '0)
		else $error("button index set without a press");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_beat, 2))
		else $error("result appeared without a sample two cycles earlier");

	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("result with no sample in flight");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= OW'(QUEUE_DEPTH + 1))
		else $error("more samples in flight than storage");

endmodule

bind adc_ladder_button_debouncer aldb_checker u_aldb_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (in.valid),
	.in_ready         (in.ready),
	.out_valid        (out.valid),
	.out_ready        (out.ready),
	.out_pressed      (out.pressed),
	.out_button_index (out.button_index)
);

### sim/adc_ladder_button_debouncer_tb.sv
// testbench of the ladder keypad decoder: predicts every press and checks each result beat
module adc_ladder_button_debouncer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import aldb_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic             pressed;
		logic [IDX_W-1:0] button;
	} press_t;

	class keypad_scoreboard;
		logic [ADC_W-1:0]     level [NUM_LEVELS];
		logic [BIU_W-1:0]     in_use;
		logic [TICKS_W-1:0]   debounce;
		logic [TICKS_W-1:0]   interval;
		logic [SAMPLES_W-1:0] need;
		logic [IDX_W-1:0]     held_button;
		logic                 held_seen;
		logic [TIME_W-1:0]    stable_since;
		logic [TIME_W-1:0]    last_press;
		logic [SAMPLES_W-1:0] run_count;
		press_t               pending_presses [$];
		int                   failures;

		function new();
			foreach (level[i])
				level[i] = '0;
			in_use = '0;
			debounce = DEBOUNCE_RST;
			interval = INTERVAL_RST;
			need = REQUIRED_RST;
			held_button = '0;
			held_seen = 1'b0;
			stable_since = '0;
			last_press = '0;
			run_count = '0;
			failures = 0;
		endfunction

		function void apply_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_LEVEL_0, REG_LEVEL_1, REG_LEVEL_2, REG_LEVEL_3: begin
					level[idx] = data[ADC_W-1:0];
				end
				REG_IN_USE: begin
					in_use = data[BIU_W-1:0];
				end
				REG_DEBOUNCE: begin
					debounce = data[TICKS_W-1:0];
				end
				REG_INTERVAL: begin
					interval = data[TICKS_W-1:0];
				end
				REG_REQUIRED: begin
					need = data[SAMPLES_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_sample(logic [TIME_W-1:0] t, logic [ADC_W-1:0] s);
			int                n, lo, hi, best, best_d, d, sv, i;
			logic              same;
			logic [TIME_W-1:0] held_for, since_press;
			press_t            r;
			r = '0;
			sv = int'(s);
			n = (int'(in_use) > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(in_use);
			if (n > 0) begin
				lo = int'(level[0]);
				hi = int'(level[0]);
				for (i = 1; i < n; i++) begin
					if (int'(level[i]) < lo)
						lo = int'(level[i]);
					if (int'(level[i]) > hi)
						hi = int'(level[i]);
				end
				if (sv + WINDOW_MARGIN_DEF >= lo && sv <= hi + WINDOW_MARGIN_DEF) begin
					best = 0;
					best_d = 1 << 30;
					for (i = 0; i < n; i++) begin
						d = (sv >= int'(level[i])) ? sv - int'(level[i]) : int'(level[i]) - sv;
						if (d < best_d) begin
							best_d = d;
							best = i;
						end
					end
					same = held_seen && (held_button == IDX_W'(best));
					if (!same) begin
						stable_since = t;
						run_count = '0;
					end else if (run_count != SAMPLES_MAX) begin
						run_count++;
					end
					held_for = t - stable_since;
					since_press = t - last_press;
					if (same && held_for >= TIME_W'(debounce) && since_press >= TIME_W'(interval)
							&& run_count >= need) begin
						last_press = t;
						r.pressed = 1'b1;
						r.button = IDX_W'(best);
					end
					held_button = IDX_W'(best);
					held_seen = 1'b1;
				end
			end
			pending_presses.push_back(r);
		endfunction

		function void check_press(logic p, logic [IDX_W-1:0] b);
			press_t e;
			if (pending_presses.size() == 0) begin
				failures++;
				$display("%0t: unexpected result beat, expected none, got pressed %0b button %0d",
					$time, p, b);
				return;
			end
			e = pending_presses.pop_front();
			if (p !== e.pressed) begin
				failures++;
				$display("%0t: pressed mismatch, expected %0b, got %0b", $time, e.pressed, p);
			end
			if (b !== e.button) begin
				failures++;
				$display("%0t: button_index mismatch, expected %0d, got %0d",
					$time, e.button, b);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	aldb_sample_if sample_ch();
	aldb_result_if result_ch();
	aldb_cfg_if    reg_ch();

	adc_ladder_button_debouncer DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (sample_ch.sink),
		.out    (result_ch.source),
		.cfg    (reg_ch.sink)
	);

	keypad_scoreboard sb;
	logic [ADC_W-1:0] lvl [NUM_LEVELS];
	int               n_use;
	int               deb_now;
	int               ivl_now;
	int               need_now;
	bit               steady;
	bit               hold_req;
	int               hold_left;
	int               cycle_count;

	always #1 clk = ~clk;

	initial begin
		sb = new();
		steady = 1'b0;
		hold_req = 1'b0;
		arst_n <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.event_time <= '0;
		sample_ch.adc_sample <= '0;
		reg_ch.valid <= 1'b0;
		reg_ch.index <= '0;
		reg_ch.wdata <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** adc_ladder_button_debouncer: FAILED **");
		$finish;
	end

	// result side, with random stalls and a long hold-off on request
	initial begin
		hold_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				sb.check_press(result_ch.pressed, result_ch.button_index);
			if (hold_req) begin
				hold_left = 80;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= steady || ($urandom_range(0, 99) >= 38);
			end
		end
	end

	task automatic send_sample(input logic [TIME_W-1:0] t, input logic [ADC_W-1:0] s);
		sample_ch.valid <= 1'b1;
		sample_ch.event_time <= t;
		sample_ch.adc_sample <= s;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		sb.note_sample(t, s);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned v);
		reg_ch.valid <= 1'b1;
		reg_ch.index <= idx;
		reg_ch.wdata <= CFG_DATA_W'(v);
		@(posedge clk);
		while (!reg_ch.ready)
			@(posedge clk);
		sb.apply_write(idx, CFG_DATA_W'(v));
	endtask

	task automatic wait_drained();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_presses.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input int unsigned l0, l1, l2, l3, biu, deb, ivl, req);
		wait_drained();
		write_reg(REG_LEVEL_0, l0);
		write_reg(REG_LEVEL_1, l1);
		write_reg(REG_LEVEL_2, l2);
		write_reg(REG_LEVEL_3, l3);
		write_reg(REG_IN_USE, biu);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_INTERVAL, ivl);
		write_reg(REG_REQUIRED, req);
		reg_ch.valid <= 1'b0;
		lvl[0] = ADC_W'(l0);
		lvl[1] = ADC_W'(l1);
		lvl[2] = ADC_W'(l2);
		lvl[3] = ADC_W'(l3);
		n_use = (biu > NUM_BUTTONS_DEF) ? NUM_BUTTONS_DEF : int'(biu);
		deb_now = int'(deb);
		ivl_now = int'(ivl);
		need_now = int'(req);
	endtask

	// mostly runs on one button with a little noise, some stray samples and time jumps
	task automatic run_phase(input int count, input int hold_at, input int pause_at);
		int                sent, run_len, b, kind, step_max, v;
		logic [TIME_W-1:0] t;
		sent = 0;
		t = $urandom;
		step_max = ((deb_now > ivl_now) ? deb_now : ivl_now) / 8 + 4;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 80 && n_use > 0) begin
				b = $urandom_range(0, n_use - 1);
				if (need_now > 30 && $urandom_range(0, 2) == 0)
					run_len = need_now + $urandom_range(1, 20);
				else
					run_len = $urandom_range(1, 30);
			end else begin
				b = -1;
				run_len = 1;
			end
			repeat (run_len) begin
				if (b >= 0) begin
					v = int'(lvl[b]) + int'($urandom_range(0, 6)) - 3;
					if (v < 0)
						v = 0;
					if (v > 1023)
						v = 1023;
				end else begin
					v = $urandom_range(0, 1023);
				end
				if (kind >= 95)
					t = $urandom;
				else
					t += $urandom_range(0, step_max);
				if (sent == hold_at)
					hold_req = 1'b1;
				if (sent == pause_at) begin
					sample_ch.valid <= 1'b0;
					do
						@(posedge clk);
					while (sb.pending_presses.size() != 0);
				end
				while (!steady && $urandom_range(0, 99) < 38) begin
					sample_ch.valid <= 1'b0;
					@(posedge clk);
				end
				send_sample(t, ADC_W'(v));
				sent++;
			end
		end
	endtask

	initial begin
		@(posedge arst_n);
		@(posedge clk);

		// decoding disabled after reset
		send_sample(32'd0, 10'd0);
		send_sample(32'hFFFF_FFFF, 10'h3FF);

		// too many buttons saturates to four; window edges and ties
		program_regs(100, 300, 600, 900, 7, 0, 0, 0);
		send_sample(32'd10, 10'd79);
		send_sample(32'd11, 10'd80);
		send_sample(32'd12, 10'd200);
		send_sample(32'd13, 10'd920);
		send_sample(32'd14, 10'd921);
		send_sample(32'd15, 10'd1023);
		send_sample(32'd16, 10'd750);
		send_sample(32'd17, 10'd749);
		send_sample(32'hFFFF_FFFF, 10'd600);
		send_sample(32'd0, 10'd600);

		// debounce, interval and count thresholds, with time wrapping
		program_regs(0, 1023, 512, 256, 4, 3, 5, 2);
		send_sample(32'd100, 10'd0);
		send_sample(32'd101, 10'd0);
		send_sample(32'd102, 10'd0);
		send_sample(32'd103, 10'd0);
		send_sample(32'd104, 10'd1023);
		send_sample(32'hFFFF_FFFE, 10'd1023);
		send_sample(32'hFFFF_FFFF, 10'd1023);
		send_sample(32'd0, 10'd1023);
		send_sample(32'd4, 10'd1023);

		program_regs(0, 1023, 511, 512, 4, 0, 0, 0);
		run_phase(175, -1, -1);

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 1, 65535, 65535, 255);
		run_phase(175, -1, -1);

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 2, $urandom_range(0, 100), $urandom_range(0, 100),
			$urandom_range(0, 8));
		run_phase(175, 40, -1);

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 3, $urandom_range(0, 40), $urandom_range(0, 40),
			$urandom_range(0, 6));
		steady = 1'b1;
		run_phase(175, -1, -1);
		steady = 1'b0;

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 0, 25, 15, 4);
		run_phase(40, -1, -1);

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 5, $urandom_range(0, 300), $urandom_range(0, 300),
			$urandom_range(0, 12));
		run_phase(175, -1, 60);

		program_regs(1023, 1023, 1023, 1023, 7, 65535, 0, 1);
		run_phase(175, -1, -1);

		program_regs($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 1023),
			$urandom_range(0, 1023), 4, 25, 15, 4);
		run_phase(240, -1, -1);

		sample_ch.valid <= 1'b0;
		while (sb.pending_presses.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("** adc_ladder_button_debouncer: PASSED **");
		else
			$display("** adc_ladder_button_debouncer: FAILED **");
		$finish;
	end

endmodule
